FILE: hdl/skts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table search package
// Table sizes, field widths, status codes and the sequencer microprogram.
// ----------------------------------------------------------------------------
package skts_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int POS_W       = 7;
  localparam int FILL_W      = 8;
  localparam int STATUS_W    = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_DUP  = 2'd2;
  localparam status_t ST_FULL = 2'd3;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_DECIDE,
    S_CHECK,
    S_SHTEST,
    S_SHMOVE,
    S_PUT,
    S_EMIT
  } step_t;

  typedef enum logic [1:0] {
    RD_MID,
    RD_PTR1,
    RD_PTR2
  } rd_sel_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CMP,
    OP_PTR,
    OP_MOVE,
    OP_PUT,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_EMPTY,
    C_LOOKUP,
    C_REFUSE,
    C_SH_DONE,
    C_SH_LAST,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic    take_in;
    rd_sel_t rd;
    op_t     op;
    cond_t   cond;
    step_t   jmp;
    step_t   seq;
  } ctrl_word_t;

  // The microprogram: jump when the condition holds, else go to seq.
  function automatic ctrl_word_t ucode(step_t s);
    ctrl_word_t w;
    w = '{take_in: 1'b0, rd: RD_MID, op: OP_NONE, cond: C_ALWAYS,
          jmp: S_IDLE, seq: S_IDLE};
    case (s)
      S_IDLE: begin
        w = '{take_in: 1'b1, rd: RD_MID, op: OP_LOAD, cond: C_NO_IN,
              jmp: S_IDLE, seq: S_SRCH};
      end
      S_SRCH: begin
        w = '{take_in: 1'b0, rd: RD_MID, op: OP_NONE, cond: C_EMPTY,
              jmp: S_DECIDE, seq: S_CMP};
      end
      S_CMP: begin
        w = '{take_in: 1'b0, rd: RD_MID, op: OP_CMP, cond: C_ALWAYS,
              jmp: S_SRCH, seq: S_SRCH};
      end
      S_DECIDE: begin
        w = '{take_in: 1'b0, rd: RD_MID, op: OP_PTR, cond: C_LOOKUP,
              jmp: S_EMIT, seq: S_CHECK};
      end
      S_CHECK: begin
        w = '{take_in: 1'b0, rd: RD_MID, op: OP_NONE, cond: C_REFUSE,
              jmp: S_EMIT, seq: S_SHTEST};
      end
      S_SHTEST: begin
        w = '{take_in: 1'b0, rd: RD_PTR1, op: OP_NONE, cond: C_SH_DONE,
              jmp: S_PUT, seq: S_SHMOVE};
      end
      S_SHMOVE: begin
        w = '{take_in: 1'b0, rd: RD_PTR2, op: OP_MOVE, cond: C_SH_LAST,
              jmp: S_PUT, seq: S_SHMOVE};
      end
      S_PUT: begin
        w = '{take_in: 1'b0, rd: RD_MID, op: OP_PUT, cond: C_ALWAYS,
              jmp: S_EMIT, seq: S_EMIT};
      end
      S_EMIT: begin
        w = '{take_in: 1'b0, rd: RD_MID, op: OP_EMIT, cond: C_OUT_BUSY,
              jmp: S_EMIT, seq: S_IDLE};
      end
      default: begin
        w = '{take_in: 1'b0, rd: RD_MID, op: OP_NONE, cond: C_ALWAYS,
              jmp: S_IDLE, seq: S_IDLE};
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/sorted_key_table_search_core.sv
`timescale 1ns / 1ps
// Lookup: each search probe reads the middle key (S_SRCH) and then compares it (S_CMP).
// Insert: after the search, each larger key is moved up one place (S_SHMOVE), then the key is put.
// A refused insert (duplicate key or full table) goes from S_CHECK straight to S_EMIT.
// The next item is taken in the cycle its result appears; a stalled earlier result holds S_EMIT.
// Reset clears the key count, the sequencer and the output valid flag.
// The key memory is not cleared; entries above the count are never read.
// ----------------------------------------------------------------------------
// Sorted key table search core
// Holds distinct signed keys in ascending order in a memory with one read and one write port.
// A microcoded sequencer runs a binary search, then for an insert shifts keys and inserts.
// ----------------------------------------------------------------------------
module sorted_key_table_search_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic signed [31:0]          key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output skts_pkg::status_t           status,
  output logic [skts_pkg::POS_W-1:0]  position,
  output logic [skts_pkg::FILL_W-1:0] fill_count
);
  import skts_pkg::*;

  step_t      pc;
  step_t      pc_next;
  ctrl_word_t cw;
  logic       cond_hit;

  logic [KEY_W-1:0] key_store [TABLE_DEPTH];
  logic [KEY_W-1:0] rdata;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic             wr_en;

  logic                    func_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hi;
  logic [CNT_W-1:0]        ptr;
  logic                    found;
  logic                    inserted;

  logic [CNT_W-1:0]        count_next;
  logic [CNT_W-1:0]        lo_next;
  logic [CNT_W-1:0]        hi_next;
  logic [CNT_W-1:0]        ptr_next;
  logic                    found_next;
  logic                    inserted_next;

  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid;
  logic [CNT_W-1:0]        ptr_m1;
  logic [CNT_W-1:0]        ptr_m2;
  logic                    in_fire;
  logic                    out_busy;
  logic                    emit_fire;
  logic signed [KEY_W-1:0] probe;

  assign cw       = ucode(pc);
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CNT_W:1];
  assign ptr_m1   = ptr - CNT_W'(1);
  assign ptr_m2   = ptr - CNT_W'(2);
  assign in_ready = cw.take_in;
  assign in_fire  = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;
  assign emit_fire = (cw.op == OP_EMIT) && !out_busy;
  assign probe    = $signed(rdata);

  always_comb begin
    case (cw.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_NO_IN:    cond_hit = !in_valid;
      C_EMPTY:    cond_hit = (lo == hi);
      C_LOOKUP:   cond_hit = (func_r == FUNC_LOOKUP);
      C_REFUSE:   cond_hit = found || (count == CNT_W'(TABLE_DEPTH));
      C_SH_DONE:  cond_hit = (ptr == lo);
      C_SH_LAST:  cond_hit = (ptr_m1 == lo);
      C_OUT_BUSY: cond_hit = out_busy;
      default:    cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    pc_next = cond_hit ? cw.jmp : cw.seq;
  end

  always_comb begin
    case (cw.rd)
      RD_MID:  rd_addr = mid[IDX_W-1:0];
      RD_PTR1: rd_addr = ptr_m1[IDX_W-1:0];
      RD_PTR2: rd_addr = ptr_m2[IDX_W-1:0];
      default: rd_addr = mid[IDX_W-1:0];
    endcase
  end

  always_comb begin
    count_next    = count;
    lo_next       = lo;
    hi_next       = hi;
    ptr_next      = ptr;
    found_next    = found;
    inserted_next = inserted;
    wr_en         = 1'b0;
    wr_addr       = lo[IDX_W-1:0];
    wr_data       = key_r;
    case (cw.op)
      OP_LOAD: begin
        lo_next       = '0;
        hi_next       = count;
        found_next    = 1'b0;
        inserted_next = 1'b0;
      end
      OP_CMP: begin
        if (probe < key_r) begin
          lo_next = mid + CNT_W'(1);
        end else begin
          hi_next = mid;
        end
        if (probe == key_r) begin
          found_next = 1'b1;
        end
      end
      OP_PTR: begin
        ptr_next = count;
      end
      OP_MOVE: begin
        wr_en    = 1'b1;
        wr_addr  = ptr[IDX_W-1:0];
        wr_data  = rdata;
        ptr_next = ptr_m1;
      end
      OP_PUT: begin
        wr_en         = 1'b1;
        count_next    = count + CNT_W'(1);
        inserted_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_store[wr_addr] <= wr_data;
    end
    rdata <= key_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      pc    <= pc_next;
      count <= count_next;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= func;
      key_r  <= key;
    end
    lo       <= lo_next;
    hi       <= hi_next;
    ptr      <= ptr_next;
    found    <= found_next;
    inserted <= inserted_next;
    if (emit_fire) begin
      fill_count <= FILL_W'(count);
      if (func_r == FUNC_LOOKUP) begin
        status   <= found ? ST_OK : ST_MISS;
        position <= found ? POS_W'(lo) : '0;
      end else begin
        status   <= found ? ST_DUP : (inserted ? ST_OK : ST_FULL);
        position <= inserted ? POS_W'(lo) : '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("key count above table depth");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (pc == S_SRCH || pc == S_CMP) |-> (lo <= hi && hi <= count))
    else $error("search bounds out of order");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (pc == S_SHMOVE) |-> (ptr > lo && ptr <= count))
    else $error("shift pointer outside the moved range");

  a_put_count: assert property (@(posedge clk) disable iff (rst)
    (pc == S_PUT) |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not raise the key count");

  a_take_start: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (pc == S_SRCH))
    else $error("accepted item did not start a search");
`endif

endmodule

FILE: tb/sv/tb_sorted_key_table_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table search core testbench
// Sends insert and lookup items into the block and compares every result,
// field by field, with a behavioral copy of the sorted key table. A short
// directed part covers the key extremes, the empty table and duplicate keys.
// Random phases follow that fill the table to its limit. These phases run
// with and without idle cycles on either side, and with one long output
// stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_sorted_key_table_search_core;
  import skts_pkg::*;

  class key_table_scoreboard;
    typedef struct {
      status_t             status;
      logic [POS_W-1:0]    position;
      logic [FILL_W-1:0]   fill;
    } table_reply_t;

    logic signed [KEY_W-1:0] held_keys [TABLE_DEPTH];
    int unsigned             held_count;
    table_reply_t            replies_due [$];
    int                      errors;

    function new();
      held_count = 0;
      errors     = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    task report(string msg);
      if (errors < 100) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      errors++;
    endtask

    function void note_item(logic f, logic signed [KEY_W-1:0] k);
      table_reply_t r;
      int           at;
      int           i;
      at = -1;
      for (i = 0; i < held_count; i++) begin
        if (held_keys[i] == k) begin
          at = i;
        end
      end
      r.position = '0;
      if (f == FUNC_LOOKUP) begin
        if (at >= 0) begin
          r.status   = ST_OK;
          r.position = at[POS_W-1:0];
        end else begin
          r.status = ST_MISS;
        end
      end else if (at >= 0) begin
        r.status = ST_DUP;
      end else if (held_count >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        i = held_count;
        while (i > 0 && held_keys[i-1] > k) begin
          held_keys[i] = held_keys[i-1];
          i--;
        end
        held_keys[i] = k;
        held_count++;
        r.status   = ST_OK;
        r.position = i[POS_W-1:0];
      end
      r.fill = held_count[FILL_W-1:0];
      replies_due.push_back(r);
    endfunction

    task check_result(status_t s, logic [POS_W-1:0] p, logic [FILL_W-1:0] fc);
      table_reply_t r;
      if (replies_due.size() == 0) begin
        report($sformatf("unexpected result status=%0d position=%0d fill=%0d",
                         s, p, fc));
      end else begin
        r = replies_due.pop_front();
        if (s !== r.status) begin
          report($sformatf("status %0d, expected %0d", s, r.status));
        end
        if (p !== r.position) begin
          report($sformatf("position %0d, expected %0d", p, r.position));
        end
        if (fc !== r.fill) begin
          report($sformatf("fill_count %0d, expected %0d", fc, r.fill));
        end
      end
    endtask
  endclass

  localparam int PHASE_ITEMS = 325;
  localparam int HOLD_CYCLES = 600;

  logic                    clk;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic                    func      = FUNC_INSERT;
  logic signed [KEY_W-1:0] key       = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  status_t                 status;
  logic [POS_W-1:0]        position;
  logic [FILL_W-1:0]       fill_count;

  key_table_scoreboard sb = new();
  int                  tx_idle_pct  = 0;
  int                  rx_stall_pct = 0;
  bit                  hold_req     = 1'b0;
  int                  rx_hold_left = 0;

  sorted_key_table_search_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .key        (key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .position   (position),
    .fill_count (fill_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        rx_hold_left = HOLD_CYCLES - 1;
        out_ready    <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(status, position, fill_count);
    end
  end

  task send_item(input logic f, input logic signed [KEY_W-1:0] k);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    key      <= k;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sb.note_item(f, k);
  endtask

  task wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) begin
      @(posedge clk);
    end
  endtask

  task run_random_phase(input int idle_pct, input int stall_pct);
    int                      n;
    int                      r;
    logic                    f;
    logic signed [KEY_W-1:0] k;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      f = ($urandom_range(99) < 35) ? FUNC_INSERT : FUNC_LOOKUP;
      r = $urandom_range(99);
      k = $urandom;
      if (f == FUNC_INSERT) begin
        if (r < 20 && sb.held_count > 0) begin
          k = sb.held_keys[$urandom_range(sb.held_count - 1)];
        end else if (r < 35) begin
          k = $signed($urandom_range(16)) - 8;
        end else if (r < 40) begin
          k = (r[0]) ? 32'sh7fffffff : 32'sh80000000;
        end
      end else if (sb.held_count > 0) begin
        if (r < 50) begin
          k = sb.held_keys[$urandom_range(sb.held_count - 1)];
        end else if (r < 70) begin
          k = sb.held_keys[$urandom_range(sb.held_count - 1)] + (r[0] ? 1 : -1);
        end
      end
      send_item(f, k);
    end
    wait_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lookups on an empty table, then extremes, duplicates and near misses.
    send_item(FUNC_LOOKUP, 32'sd0);
    send_item(FUNC_LOOKUP, 32'sh80000000);
    send_item(FUNC_INSERT, 32'sd0);
    send_item(FUNC_INSERT, 32'sh7fffffff);
    send_item(FUNC_INSERT, 32'sh80000000);
    send_item(FUNC_INSERT, -32'sd1);
    send_item(FUNC_INSERT, 32'sd1);
    send_item(FUNC_INSERT, 32'sd0);
    send_item(FUNC_INSERT, 32'sh80000000);
    send_item(FUNC_INSERT, 32'sh7fffffff);
    send_item(FUNC_LOOKUP, 32'sh80000000);
    send_item(FUNC_LOOKUP, 32'sh7fffffff);
    send_item(FUNC_LOOKUP, 32'sd0);
    send_item(FUNC_LOOKUP, -32'sd1);
    send_item(FUNC_LOOKUP, 32'sd1);
    send_item(FUNC_LOOKUP, 32'sd2);
    send_item(FUNC_LOOKUP, -32'sd2);
    send_item(FUNC_LOOKUP, 32'sh7ffffffe);
    send_item(FUNC_LOOKUP, 32'sh80000001);
    wait_drain();

    run_random_phase(0, 0);
    run_random_phase(47, 0);

    // The output holds off while the sender keeps offering items.
    tx_idle_pct = 0;
    hold_req    = 1'b1;
    run_random_phase(0, 47);
    run_random_phase(25, 25);

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/skts_pkg.sv
hdl/sorted_key_table_search_core.sv
tb/sv/tb_sorted_key_table_search_core.sv
